@@ sv/sli_pkg.sv @@
// sli_pkg: shared constants and types for the sorted list insert/delete block
// used by sli_ctrl, sli_datapath and sorted_list_insert_delete_top; no dependencies

package sli_pkg;

	// default list capacity
	localparam int CAPACITY_DEF = 16;

	// operation codes carried on the input selector
	localparam logic MODE_INSERT = 1'b0;
	localparam logic MODE_DELETE = 1'b1;

	// result status codes
	localparam logic [1:0] ST_INSERTED  = 2'd0;
	localparam logic [1:0] ST_DELETED   = 2'd1;
	localparam logic [1:0] ST_NOT_FOUND = 2'd2;
	localparam logic [1:0] ST_FULL      = 2'd3;

	// commands from controller to datapath
	typedef struct packed {
		logic load;  // capture the incoming item
		logic cmp;   // register the per-entry compare flags
		logic upd;   // apply the insert or delete
		logic emit;  // push one list item into the output register
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic out_free;   // output register can take an item this cycle
		logic last_emit;  // the next emitted item closes the run
	} sts_t;

endpackage

@@ sv/sli_ctrl.sv @@
// sli_ctrl: sequencer for the sorted list block (accept, compare, update, emit)
// depends on sli_pkg for the command and status structs

module sli_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	input  sli_pkg::sts_t sts,
	output sli_pkg::cmd_t cmd
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_CMP  = 2'd1;
	localparam logic [1:0] S_UPD  = 2'd2;
	localparam logic [1:0] S_EMIT = 2'd3;

	logic [1:0] state_q;
	logic [1:0] state_nxt;

	assign s_tready = (state_q == S_IDLE);

	// next state and command decode
	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.load  = 1'b1;
					state_nxt = S_CMP;
				end
			end
			S_CMP: begin
				cmd.cmp   = 1'b1;
				state_nxt = S_UPD;
			end
			S_UPD: begin
				cmd.upd   = 1'b1;
				state_nxt = S_EMIT;
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					if (sts.last_emit) begin
						state_nxt = S_IDLE;
					end
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

@@ sv/sli_datapath.sv @@
// sli_datapath: row of list cells with parallel compare, shift and rotate, plus output register
// depends on sli_pkg for codes and the command and status structs

module sli_datapath #(
	parameter int CAPACITY = sli_pkg::CAPACITY_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  sli_pkg::cmd_t                    cmd,
	output sli_pkg::sts_t                    sts,
	input  logic                             in_mode,
	input  logic [31:0]                      in_value,
	input  logic                             m_tready,
	output logic                             m_tvalid,
	output logic [31:0]                      m_tdata,
	output logic [2:0]                       m_tuser,
	output logic                             m_tlast,
	output logic [$clog2(CAPACITY+1)-1:0]    entry_cnt
);

	localparam int IW = $clog2(CAPACITY);
	localparam int CW = $clog2(CAPACITY + 1);

	logic [31:0]         ent_q [CAPACITY];
	logic [CW-1:0]       cnt_q;
	logic [IW-1:0]       idx_q;
	logic                mode_q;
	logic [31:0]         val_q;
	logic [CAPACITY-1:0] lt_q;
	logic [1:0]          stat_q;

	logic                m_tvalid_q;
	logic [31:0]         m_data_q;
	logic                m_elem_valid_q;
	logic                m_last_q;
	logic [1:0]          m_stat_q;

	logic [CAPACITY-1:0] in_list;
	logic [CAPACITY-1:0] lt_nxt;
	logic [CAPACITY-1:0] lt_prev;
	logic [CAPACITY-1:0] hit;
	logic                found;
	logic                full;
	logic                cnt_zero;
	logic [IW-1:0]       cnt_last;
	logic [31:0]         ent_dn  [CAPACITY];
	logic [31:0]         ent_up  [CAPACITY];
	logic [31:0]         ent_ins [CAPACITY];
	logic [31:0]         ent_del [CAPACITY];
	logic [31:0]         ent_rot [CAPACITY];

	assign full     = (cnt_q == CW'(CAPACITY));
	assign cnt_zero = (cnt_q == '0);
	assign cnt_last = IW'(cnt_q - CW'(1));
	assign lt_prev  = {lt_q[CAPACITY-2:0], 1'b1};
	assign found    = |hit;

	// neighbour taps of each cell
	for (genvar g = 0; g < CAPACITY; g++) begin : g_tap
		if (g == 0) begin : g_first
			assign ent_dn[g] = val_q;
		end else begin : g_rest
			assign ent_dn[g] = ent_q[g-1];
		end
		if (g == CAPACITY - 1) begin : g_top
			assign ent_up[g] = '0;
		end else begin : g_mid
			assign ent_up[g] = ent_q[g+1];
		end
	end

	// per-cell compare, match and next values
	always_comb begin
		for (int i = 0; i < CAPACITY; i++) begin
			in_list[i] = (CW'(i) < cnt_q);
			lt_nxt[i]  = in_list[i] && ($signed(ent_q[i]) < $signed(val_q));
			hit[i]     = !lt_q[i] && lt_prev[i] && in_list[i] && (ent_q[i] == val_q);
			ent_ins[i] = lt_q[i] ? ent_q[i] : (lt_prev[i] ? val_q : ent_dn[i]);
			ent_del[i] = lt_q[i] ? ent_q[i] : ent_up[i];
			ent_rot[i] = (IW'(i) == cnt_last) ? ent_q[0] : ent_up[i];
		end
	end

	// list cells and entry count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CAPACITY; i++) begin
				ent_q[i] <= '0;
			end
			cnt_q <= '0;
			idx_q <= '0;
		end else begin
			if (cmd.upd) begin
				idx_q <= '0;
				if (mode_q == sli_pkg::MODE_INSERT) begin
					if (!full) begin
						ent_q <= ent_ins;
						cnt_q <= cnt_q + CW'(1);
					end
				end else if (found) begin
					ent_q <= ent_del;
					cnt_q <= cnt_q - CW'(1);
				end
			end else if (cmd.emit) begin
				idx_q <= idx_q + IW'(1);
				if (!cnt_zero) begin
					ent_q <= ent_rot;
				end
			end
		end
	end

	// operand, compare flags and run status
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			mode_q <= in_mode;
			val_q  <= in_value;
		end
		if (cmd.cmp) begin
			lt_q <= lt_nxt;
		end
		if (cmd.upd) begin
			if (mode_q == sli_pkg::MODE_INSERT) begin
				stat_q <= full ? sli_pkg::ST_FULL : sli_pkg::ST_INSERTED;
			end else begin
				stat_q <= found ? sli_pkg::ST_DELETED : sli_pkg::ST_NOT_FOUND;
			end
		end
	end

	// output register, valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.emit) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// output register, item fields
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			m_data_q       <= cnt_zero ? 32'd0 : ent_q[0];
			m_elem_valid_q <= !cnt_zero;
			m_last_q       <= sts.last_emit;
			m_stat_q       <= stat_q;
		end
	end

	assign sts.out_free  = !m_tvalid_q || m_tready;
	assign sts.last_emit = cnt_zero || (idx_q == cnt_last);

	assign m_tvalid  = m_tvalid_q;
	assign m_tdata   = m_data_q;
	assign m_tuser   = {m_elem_valid_q, m_stat_q};
	assign m_tlast   = m_last_q;
	assign entry_cnt = cnt_q;

endmodule

@@ sv/sorted_list_insert_delete_top.sv @@
// sorted_list_insert_delete_top: ascending list of signed words with insert and delete
// depends on sli_pkg, sli_ctrl and sli_datapath
//
// channel  dir  handshake          payload
// s_*      in   s_tvalid/s_tready  s_tdata = value, s_tuser = mode
// m_*      out  m_tvalid/m_tready  m_tdata = element_value, m_tuser = status, element_valid;
//                                  m_tlast = last_element
//
// one item passes accept, parallel compare over all cells and shift update, then one list item
// per cycle while the output is not stalled, read from the head cell while the cell row rotates
// back to its original order; an empty list still gives one item.
// reset clears the list at once; no clearing pass.
// a stalled output holds the emit phase; the next item is taken while the last one waits.

module sorted_list_insert_delete_top #(
	parameter int CAPACITY = sli_pkg::CAPACITY_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,   // [31:0] value
	input  logic [0:0]  s_tuser,   // [0] mode
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,   // [31:0] element_value
	output logic [2:0]  m_tuser,   // [1:0] status, [2] element_valid
	output logic        m_tlast
);

	localparam int CW = $clog2(CAPACITY + 1);

	sli_pkg::cmd_t  cmd;
	sli_pkg::sts_t  sts;
	logic [CW-1:0]  entry_cnt;

	// sequencer
	sli_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	// list cells and output register
	sli_datapath #(
		.CAPACITY (CAPACITY)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.sts       (sts),
		.in_mode   (s_tuser[0]),
		.in_value  (s_tdata),
		.m_tready  (m_tready),
		.m_tvalid  (m_tvalid),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser),
		.m_tlast   (m_tlast),
		.entry_cnt (entry_cnt)
	);

	// list length never passes the capacity
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		entry_cnt <= CW'(CAPACITY))
		else $error("entry count above capacity");

	// an empty-list item is always the whole run
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tuser[2] |-> m_tlast)
		else $error("empty-list item without last mark");

	// one item at a time: no accept right after an accept
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken while an item is in progress");

	// the closing item of a run shows up with its last mark
	a_last_shown: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.emit && sts.last_emit && !m_tvalid |=> m_tvalid && m_tlast)
		else $error("closing item not presented");

endmodule
